// File: design/lzss_ring_decoder_core_defines.svh
// Assertion macros shared by the LZSS ring decoder RTL.
// Expects clk and rst_n in the scope of use.
`ifndef LZSS_RING_DECODER_CORE_DEFINES_SVH
`define LZSS_RING_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define LZSD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzsd assertion failed");

// next-cycle implication
`define LZSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzsd assertion failed");

`endif

// File: design/lzsd_pkg.sv
// Package for the LZSS ring decoder: beat types and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package lzsd_pkg;

  localparam int          LOOKAHEAD  = 16;
  localparam int          MIN_LEN    = 3;
  localparam int          MAX_LEN    = 18;
  localparam logic [7:0]  FILL_BYTE  = 8'h20;
  localparam logic [3:0]  FLAG_COUNT = 4'd8;
  localparam logic [1:0]  PH_TOKEN   = 2'd0;
  localparam logic [1:0]  PH_REF_HI  = 2'd1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_stream;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

endpackage

// File: design/lzsd_ring.sv
// History ring storage: one write port, one registered read port.
// Depends on nothing; instantiated by lzss_ring_decoder_core.
`timescale 1ns / 1ps

module lzsd_ring #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while no read is issued
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/lzss_ring_decoder_core.sv
// LZSS decoder with a 4 KiB history window.
// Depends on lzsd_pkg, lzsd_ring and lzss_ring_decoder_core_defines.svh.
//
// Usage:
//   in_valid/in_ready/in_data carry one compressed byte per beat, with
//   new_stream restarting ring, write position and parser before that byte.
//   out_valid/out_ready/out_data carry one decoded byte per beat, with
//   last_of_run set on the final byte that one input beat produces.
// Data flow:
//   Flag bytes and the first byte of a reference give no output. An
//   accepted literal passes through the copy stage into the output
//   register. A reference expands to 3..18 bytes, one ring read per cycle
//   while the copy stage can advance; in_ready stays low until the copy
//   ends, so the next input beat waits for the whole reference.
// Reset and stalls:
//   rst_n (synchronous, active low) puts the parser at "expect flag byte",
//   the write position at 4080 and marks the whole ring as unwritten; an
//   unwritten entry reads as a space below 4080 and zero from 4080 up, tracked by
//   a fill count, so no clearing pass is needed.
//   A low out_ready holds a full copy stage and then drops in_ready; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "lzss_ring_decoder_core_defines.svh"

module lzss_ring_decoder_core #(
  parameter int RING_SIZE = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lzsd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lzsd_pkg::out_t out_data
);

  localparam int AW = $clog2(RING_SIZE);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] START_POS = AW'(RING_SIZE - lzsd_pkg::LOOKAHEAD);
  localparam logic [CW-1:0] FULL_CNT  = CW'(RING_SIZE);

  typedef enum logic {ST_IDLE, ST_COPY} state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [7:0]      flag_bits_r, flag_bits_nxt;
  logic [3:0]      flags_left_r, flags_left_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [7:0]      ref_low_r, ref_low_nxt;
  logic [AW-1:0]   cp_addr_r, cp_addr_nxt;
  logic [4:0]      cp_left_r, cp_left_nxt;
  // copy stage between ring read and output register
  logic            s1_v_r, s1_v_nxt;
  logic            s1_mem_r, s1_mem_nxt;
  logic [7:0]      s1_alt_r, s1_alt_nxt;
  logic            s1_last_r, s1_last_nxt;
  logic            out_valid_r, out_valid_nxt;
  lzsd_pkg::out_t  out_data_r, out_data_nxt;

  logic            s1_adv, accept, rd_en, fwd, written;
  logic [7:0]      s1_byte, rd_data, dflt_byte;
  logic [AW-1:0]   rd_off;
  logic [3:0]      fl_eff;
  logic [1:0]      ph_eff;

  lzsd_ring #(.DEPTH(RING_SIZE), .AW(AW)) u_ring (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (wp_r),
    .wr_data (s1_byte),
    .rd_en   (rd_en),
    .rd_addr (cp_addr_r),
    .rd_data (rd_data)
  );

  assign s1_byte  = s1_mem_r ? rd_data : s1_alt_r;
  assign s1_adv   = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE) && (!s1_v_r || s1_adv);
  assign accept   = in_valid && in_ready;
  assign rd_en    = (state_r == ST_COPY) && (!s1_v_r || s1_adv);

  // entries written since restart form the window [START_POS, START_POS + cnt)
  assign rd_off    = cp_addr_r - START_POS;
  assign written   = {1'b0, rd_off} < cnt_r;
  assign fwd       = s1_adv && (cp_addr_r == wp_r);
  assign dflt_byte = (cp_addr_r < START_POS) ? lzsd_pkg::FILL_BYTE : 8'h00;

  assign fl_eff = in_data.new_stream ? 4'd0 : flags_left_r;
  assign ph_eff = in_data.new_stream ? lzsd_pkg::PH_TOKEN : phase_r;

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    cnt_nxt        = cnt_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    phase_nxt      = phase_r;
    ref_low_nxt    = ref_low_r;
    cp_addr_nxt    = cp_addr_r;
    cp_left_nxt    = cp_left_r;
    s1_v_nxt       = s1_v_r;
    s1_mem_nxt     = s1_mem_r;
    s1_alt_nxt     = s1_alt_r;
    s1_last_nxt    = s1_last_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.out_byte    = s1_byte;
      out_data_nxt.last_of_run = s1_last_r;
      s1_v_nxt              = 1'b0;
      wp_nxt                = wp_r + AW'(1);
      if (cnt_r != FULL_CNT) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end

    if (rd_en) begin
      s1_v_nxt    = 1'b1;
      s1_mem_nxt  = !fwd && written;
      s1_alt_nxt  = fwd ? s1_byte : dflt_byte;
      s1_last_nxt = (cp_left_r == 5'd1);
      cp_addr_nxt = cp_addr_r + AW'(1);
      cp_left_nxt = cp_left_r - 5'd1;
      if (cp_left_r == 5'd1) begin
        state_nxt = ST_IDLE;
      end
    end

    if (accept) begin
      if (in_data.new_stream) begin
        wp_nxt  = START_POS;
        cnt_nxt = '0;
      end
      if (fl_eff == 4'd0) begin
        flag_bits_nxt  = in_data.in_byte;
        flags_left_nxt = lzsd_pkg::FLAG_COUNT;
        phase_nxt      = lzsd_pkg::PH_TOKEN;
      end else if (ph_eff == lzsd_pkg::PH_TOKEN) begin
        if (flag_bits_r[0]) begin
          s1_v_nxt       = 1'b1;
          s1_mem_nxt     = 1'b0;
          s1_alt_nxt     = in_data.in_byte;
          s1_last_nxt    = 1'b1;
          flag_bits_nxt  = {1'b0, flag_bits_r[7:1]};
          flags_left_nxt = flags_left_r - 4'd1;
        end else begin
          ref_low_nxt = in_data.in_byte;
          phase_nxt   = lzsd_pkg::PH_REF_HI;
        end
      end else begin
        cp_addr_nxt    = AW'({in_data.in_byte[7:4], ref_low_r});
        cp_left_nxt    = {1'b0, in_data.in_byte[3:0]} + 5'(lzsd_pkg::MIN_LEN);
        state_nxt      = ST_COPY;
        phase_nxt      = lzsd_pkg::PH_TOKEN;
        flag_bits_nxt  = {1'b0, flag_bits_r[7:1]};
        flags_left_nxt = flags_left_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wp_r         <= START_POS;
      cnt_r        <= '0;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      phase_r      <= lzsd_pkg::PH_TOKEN;
      s1_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      cnt_r        <= cnt_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      phase_r      <= phase_nxt;
      s1_v_r       <= s1_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    ref_low_r   <= ref_low_nxt;
    cp_addr_r   <= cp_addr_nxt;
    cp_left_r   <= cp_left_nxt;
    s1_mem_r    <= s1_mem_nxt;
    s1_alt_r    <= s1_alt_nxt;
    s1_last_r   <= s1_last_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LZSD_ASSERT_IMPL(a_ready_only_idle, in_ready, state_r == ST_IDLE)
  `LZSD_ASSERT_NEXT(a_read_fills_stage, rd_en, s1_v_r)
  `LZSD_ASSERT_IMPL(a_copy_len_range, state_r == ST_COPY,
                    (cp_left_r != 5'd0) && (cp_left_r <= 5'(lzsd_pkg::MAX_LEN)))
  `LZSD_ASSERT_IMPL(a_fill_cnt_bound, 1'b1, cnt_r <= FULL_CNT)

endmodule
